// ----- rtl/core/dis_pkg.sv -----
// Shared types and constants for the date insertion sorter.
package dis_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int DAY_W       = 5;
    localparam int MONTH_W     = 4;
    localparam int YEAR_W      = 14;
    localparam int KEY_W       = YEAR_W + MONTH_W + DAY_W;

    // Packed so that unsigned order is year, then month, then day.
    typedef logic [KEY_W-1:0] t_key;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic insert;
        logic shift;
    } t_cell_cmd;

endpackage

// ----- rtl/core/date_insertion_sorter_unit.sv -----
// Date insertion sorter: a row of compare-and-shift cells with a drain controller.
//
// Input: a transaction is taken at a rising edge where start is high and busy is
// low. Each date is inserted into a sorted row of TABLE_DEPTH cells at that same
// edge; all cells compare against the new key at once, so a new date may follow
// in the very next cycle while no run is being emitted.
// When the date carries i_final_item, busy goes high in the next cycle and the
// stored dates leave the row one per cycle, smallest first, on o_out_* with
// o_strobe high, as the row shifts toward cell 0; a run holds as many dates as
// are stored (1 to TABLE_DEPTH). o_end_of_run marks the last date, and busy
// falls in the cycle after it. Dates arriving while the row is full are dropped;
// o_dropped_some is then high on every result of that run.
// The receiver cannot stall: every result is valid for exactly one cycle.
// Reset (synchronous, active low) empties the row and clears the drop flag;
// the block can take a transaction in the first cycle after reset.
module date_insertion_sorter_unit
    import dis_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [DAY_W-1:0]     i_day,
    input  logic [MONTH_W-1:0]   i_month,
    input  logic [YEAR_W-1:0]    i_year,
    input  logic                 i_final_item,
    output logic                 o_strobe,
    output logic [DAY_W-1:0]     o_out_day,
    output logic [MONTH_W-1:0]   o_out_month,
    output logic [YEAR_W-1:0]    o_out_year,
    output logic                 o_end_of_run,
    output logic                 o_dropped_some
);

    t_state    r_state;
    t_state    n_state;
    logic      r_overflow;
    logic      n_overflow;
    logic      w_accept;
    logic      w_full;
    t_key      w_new_key;
    t_cell_cmd w_cmd;

    t_key w_key   [TABLE_DEPTH];
    logic w_valid [TABLE_DEPTH];
    logic w_gt    [TABLE_DEPTH];

    assign w_new_key = {i_year, i_month, i_day};
    assign w_accept  = start && !busy;
    assign w_full    = w_valid[TABLE_DEPTH-1];

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        t_key l_left_key;
        logic l_left_valid;
        logic l_left_gt;
        t_key l_right_key;
        logic l_right_valid;

        if (g == 0) begin : g_head
            assign l_left_key   = w_new_key;
            assign l_left_valid = 1'b1;
            assign l_left_gt    = 1'b0;
        end else begin : g_body
            assign l_left_key   = w_key[g-1];
            assign l_left_valid = w_valid[g-1];
            assign l_left_gt    = w_gt[g-1];
        end

        if (g == TABLE_DEPTH - 1) begin : g_tail
            assign l_right_key   = w_key[g];
            assign l_right_valid = 1'b0;
        end else begin : g_mid
            assign l_right_key   = w_key[g+1];
            assign l_right_valid = w_valid[g+1];
        end

        dis_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_cmd         (w_cmd),
            .i_key         (w_new_key),
            .i_left_key    (l_left_key),
            .i_left_valid  (l_left_valid),
            .i_left_gt     (l_left_gt),
            .i_right_key   (l_right_key),
            .i_right_valid (l_right_valid),
            .o_key         (w_key[g]),
            .o_valid       (w_valid[g]),
            .o_gt          (w_gt[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_overflow <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_overflow <= n_overflow;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_overflow   = r_overflow;
        w_cmd        = '0;
        busy         = 1'b0;
        o_strobe     = 1'b0;
        o_end_of_run = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    w_cmd.insert = !w_full;
                    if (w_full) begin
                        n_overflow = 1'b1;
                    end
                    if (i_final_item) begin
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                busy         = 1'b1;
                o_strobe     = 1'b1;
                w_cmd.shift  = 1'b1;
                o_end_of_run = !w_valid[1];
                if (!w_valid[1]) begin
                    n_state    = ST_IDLE;
                    n_overflow = 1'b0;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_day      = w_key[0][DAY_W-1:0];
    assign o_out_month    = w_key[0][DAY_W +: MONTH_W];
    assign o_out_year     = w_key[0][KEY_W-1 -: YEAR_W];
    assign o_dropped_some = r_overflow;

`ifndef NO_ASSERTIONS
    a_strobe_has_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> w_valid[0])
        else $error("result emitted from an empty cell");

    a_run_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_end_of_run) |=> (!busy && !o_strobe && !w_valid[0]))
        else $error("row not empty after the end of a run");

    a_final_starts_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_final_item) |=> (o_strobe && busy))
        else $error("final transaction did not start a run");
`endif

endmodule

// ----- rtl/core/dis_cell.sv -----
// One slot of the sorting chain: holds a key and moves it up or down the row.
module dis_cell
    import dis_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_cmd i_cmd,
    input  t_key      i_key,
    input  t_key      i_left_key,
    input  logic      i_left_valid,
    input  logic      i_left_gt,
    input  t_key      i_right_key,
    input  logic      i_right_valid,
    output t_key      o_key,
    output logic      o_valid,
    output logic      o_gt
);

    t_key r_key;
    t_key n_key;
    logic r_valid;
    logic n_valid;

    // Strict compare keeps the insertion stable: equal keys stay ahead.
    assign o_gt = !r_valid || (r_key > i_key);

    always_comb begin
        n_key   = r_key;
        n_valid = r_valid;
        if (i_cmd.shift) begin
            n_key   = i_right_key;
            n_valid = i_right_valid;
        end else if (i_cmd.insert && o_gt) begin
            // The first greater slot takes the new key, the rest take their left neighbor.
            n_key   = i_left_gt ? i_left_key : i_key;
            n_valid = r_valid | i_left_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    assign o_key   = r_key;
    assign o_valid = r_valid;

endmodule

// ----- tb/sv/tb_date_insertion_sorter_unit.sv -----
// Self-checking testbench for the date insertion sorter unit.
module tb_date_insertion_sorter_unit
    import dis_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic               run_end;
        logic               dropped;
    } t_sorted_date;

    localparam int RANDOM_ITEMS = 410;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [DAY_W-1:0]   i_day = '0;
    logic [MONTH_W-1:0] i_month = '0;
    logic [YEAR_W-1:0]  i_year = '0;
    logic               i_final_item = 1'b0;
    logic               o_strobe;
    logic [DAY_W-1:0]   o_out_day;
    logic [MONTH_W-1:0] o_out_month;
    logic [YEAR_W-1:0]  o_out_year;
    logic               o_end_of_run;
    logic               o_dropped_some;

    // Model of the table contents and the dates still owed by the block.
    t_key         date_row[$];
    logic         overflow_seen = 1'b0;
    t_sorted_date sorted_dates[$];
    int           mismatch_count = 0;
    int           sent_count = 0;
    int           gap_limit = 16;

    date_insertion_sorter_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_day         (i_day),
        .i_month       (i_month),
        .i_year        (i_year),
        .i_final_item  (i_final_item),
        .o_strobe      (o_strobe),
        .o_out_day     (o_out_day),
        .o_out_month   (o_out_month),
        .o_out_year    (o_out_year),
        .o_end_of_run  (o_end_of_run),
        .o_dropped_some(o_dropped_some)
    );

    always #2 i_clk = ~i_clk;

    // Stable insertion: the new date goes after every stored date equal to it.
    task automatic insert_date(input t_key key, input logic last_of_set);
        int pos;
        if (date_row.size() < TABLE_DEPTH) begin
            pos = date_row.size();
            while (pos > 0 && date_row[pos-1] > key) pos--;
            date_row.insert(pos, key);
        end else begin
            overflow_seen = 1'b1;
        end
        if (last_of_set) begin
            foreach (date_row[k]) begin
                sorted_dates.push_back(t_sorted_date'{
                    day:     date_row[k][DAY_W-1:0],
                    month:   date_row[k][DAY_W +: MONTH_W],
                    year:    date_row[k][DAY_W+MONTH_W +: YEAR_W],
                    run_end: (k == date_row.size() - 1),
                    dropped: overflow_seen});
            end
            date_row.delete();
            overflow_seen = 1'b0;
        end
    endtask

    // Results are checked before the transaction of the same edge is applied.
    always @(posedge i_clk) begin : result_check
        t_sorted_date want;
        if (o_strobe === 1'b1) begin
            if (sorted_dates.size() == 0) begin
                $display("%0t: unexpected date, expected none, got %0d-%0d-%0d", $time,
                         o_out_year, o_out_month, o_out_day);
                mismatch_count++;
            end else begin
                want = sorted_dates.pop_front();
                if (o_out_day !== want.day) begin
                    $display("%0t: day expected %0d, got %0d", $time, want.day, o_out_day);
                    mismatch_count++;
                end
                if (o_out_month !== want.month) begin
                    $display("%0t: month expected %0d, got %0d", $time, want.month,
                             o_out_month);
                    mismatch_count++;
                end
                if (o_out_year !== want.year) begin
                    $display("%0t: year expected %0d, got %0d", $time, want.year,
                             o_out_year);
                    mismatch_count++;
                end
                if (o_end_of_run !== want.run_end) begin
                    $display("%0t: end_of_run expected %0b, got %0b", $time, want.run_end,
                             o_end_of_run);
                    mismatch_count++;
                end
                if (o_dropped_some !== want.dropped) begin
                    $display("%0t: dropped_some expected %0b, got %0b", $time, want.dropped,
                             o_dropped_some);
                    mismatch_count++;
                end
            end
        end
        if (i_rst_n === 1'b1 && start === 1'b1 && busy === 1'b0)
            insert_date({i_year, i_month, i_day}, i_final_item);
    end

    task automatic send_date(input t_key key, input logic last_of_set);
        int idle;
        idle = $urandom_range(0, gap_limit);
        if (idle > 0) begin
            start <= 1'b0;
            repeat (idle) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_day        <= key[DAY_W-1:0];
        i_month      <= key[DAY_W +: MONTH_W];
        i_year       <= key[DAY_W+MONTH_W +: YEAR_W];
        i_final_item <= last_of_set;
        do @(posedge i_clk); while (busy);
        sent_count++;
    endtask

    task automatic wait_for_drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (sorted_dates.size() != 0 || busy) @(posedge i_clk);
    endtask

    function automatic t_key random_date();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return t_key'($urandom);
        // A narrow pool of dates makes equal keys and near ties common.
        if (pick <= 2)
            return {YEAR_W'(2000 + $urandom_range(0, 1)), MONTH_W'($urandom_range(1, 2)),
                    DAY_W'($urandom_range(1, 2))};
        return {YEAR_W'($urandom_range(0, 9999)), MONTH_W'($urandom_range(1, 12)),
                DAY_W'($urandom_range(1, 31))};
    endfunction

    task automatic send_random_set(input int set_len);
        gap_limit = ($urandom_range(0, 3) == 0) ? 0 : 16;
        for (int n = 1; n <= set_len; n++)
            send_date(random_date(), n == set_len);
    endtask

    task automatic test_directed_dates();
        // Raw field extremes, calendar limits and an exact duplicate in one set.
        send_date({14'd0, 4'd0, 5'd0}, 1'b0);
        send_date({14'd16383, 4'd15, 5'd31}, 1'b0);
        send_date({14'd9999, 4'd12, 5'd31}, 1'b0);
        send_date({14'd0, 4'd1, 5'd1}, 1'b0);
        send_date({14'd2024, 4'd6, 5'd15}, 1'b0);
        send_date({14'd2024, 4'd6, 5'd15}, 1'b0);
        send_date({14'd2024, 4'd6, 5'd14}, 1'b1);
        // A set made of the final date alone.
        send_date({14'd1999, 4'd12, 5'd31}, 1'b1);
        // Ties on year and on month, arriving in descending order.
        gap_limit = 0;
        send_date({14'd2001, 4'd1, 5'd1}, 1'b0);
        send_date({14'd2000, 4'd12, 5'd1}, 1'b0);
        send_date({14'd2000, 4'd1, 5'd31}, 1'b0);
        send_date({14'd2000, 4'd1, 5'd1}, 1'b0);
        send_date({14'd1999, 4'd12, 5'd31}, 1'b1);
        gap_limit = 16;
    endtask

    task automatic test_table_overflow();
        // Exactly full, full before the final date, and well past full.
        send_random_set(TABLE_DEPTH);
        send_random_set(TABLE_DEPTH + 1);
        wait_for_drain();
        send_random_set(TABLE_DEPTH + 8);
        wait_for_drain();
    endtask

    task automatic test_random_sets();
        int pick;
        while (sent_count < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                send_random_set($urandom_range(TABLE_DEPTH + 1, TABLE_DEPTH + 8));
            else if (pick <= 2)
                send_random_set($urandom_range(9, TABLE_DEPTH));
            else
                send_random_set($urandom_range(1, 8));
            if ($urandom_range(0, 7) == 0)
                wait_for_drain();
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_dates();
        test_table_overflow();
        test_random_sets();
        wait_for_drain();
        repeat (TABLE_DEPTH + 8) @(posedge i_clk);
        if (mismatch_count == 0 && sorted_dates.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
